/* rtl/mrl_pkg.sv */
package mrl_pkg;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic insert;
        logic remove;
        logic rotate;
        logic hit;
    } cell_ctl_t;

    localparam int unsigned CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

endpackage

/* rtl/mrl_cell.sv */
module mrl_cell
    import mrl_pkg::*;
#(
    parameter int unsigned KEY_BITS = 64
) (
    input  logic                aclk,
    input  cell_ctl_t           ctl,
    input  logic [KEY_BITS-1:0] new_key,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [KEY_BITS-1:0] right_key,
    input  logic [KEY_BITS-1:0] head_key,
    input  logic                in_list,
    input  logic                fill_ok,
    input  logic                is_tail,
    input  logic                seen_in,
    output logic                seen_out,
    output logic [KEY_BITS-1:0] key_out
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                match;

    assign match    = in_list && (key_reg == new_key);
    assign seen_out = seen_in || match;
    assign key_out  = key_reg;

    always_comb begin
        key_next = key_reg;
        priority if (ctl.insert && (ctl.hit ? !seen_in : fill_ok)) begin
            key_next = left_key;
        end else if (ctl.remove && seen_out) begin
            // close the gap left by the removed key
            key_next = right_key;
        end else if (ctl.rotate && in_list) begin
            key_next = is_tail ? head_key : right_key;
        end else begin
            key_next = key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

/* rtl/mru_recency_list_top.sv */
// Most-recently-used list of distinct keys, newest first, held in a chain of
// MAX_ENTRIES cells that each compare against the request key and pass their
// key to a neighbor. Insert, remove and clear may follow one another back to
// back. A read holds off further requests until its last result is registered,
// giving one result per entry (a single result for an empty list) and waiting
// whenever the result side stalls: the chain rotates by one place per result
// so the head cell feeds the output, and after the last result the list is
// back in its original order. A request can be taken as soon as reset is
// released; no clearing pass is needed.
module mru_recency_list_top
    import mrl_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 16,
    parameter int unsigned KEY_BITS    = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CAP_BITS-1:0]                  cfg_data,   // capacity
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((2+KEY_BITS+7)/8)*8-1:0]      s_tdata,    // mode, key
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((KEY_BITS+7)/8)*8-1:0]        m_tdata,    // entry_key
    output logic                                 m_tuser,    // list_empty
    output logic                                 m_tlast
);

    localparam int unsigned OUT_W = ((KEY_BITS + 7) / 8) * 8;
    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

    logic [CAP_BITS-1:0] cap_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic                out_empty_reg, out_empty_next;
    logic                out_last_reg, out_last_next;

    logic [KEY_BITS-1:0] cell_key [MAX_ENTRIES];
    logic [MAX_ENTRIES:0] seen;
    cell_ctl_t           ctl;
    mode_t               mode;
    logic [KEY_BITS-1:0] req_key;
    logic                accept;
    logic                out_free;
    logic [CNT_W-1:0]    eff_cap;
    logic [CNT_W-1:0]    trimmed;

    assign mode     = mode_t'(s_tdata[1:0]);
    assign req_key  = s_tdata[KEY_BITS+1:2];
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign cfg_ready = aresetn;

    // zero acts as one, anything above the chain length as the chain length
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(cap_reg) > MAX_ENTRIES) begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign trimmed = (count_reg >= eff_cap) ? eff_cap - CNT_W'(1) : count_reg;

    assign seen[0] = 1'b0;

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [KEY_BITS-1:0] left_key;
        logic [KEY_BITS-1:0] right_key;

        if (i == 0) begin : g_head
            assign left_key = req_key;
        end else begin : g_body
            assign left_key = cell_key[i-1];
        end

        if (i == MAX_ENTRIES - 1) begin : g_end
            assign right_key = cell_key[i];
        end else begin : g_mid
            assign right_key = cell_key[i+1];
        end

        mrl_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .new_key   (req_key),
            .left_key  (left_key),
            .right_key (right_key),
            .head_key  (cell_key[0]),
            .in_list   (CNT_W'(i) < count_reg),
            .fill_ok   (CNT_W'(i) <= trimmed),
            .is_tail   (CNT_W'(i + 1) == count_reg),
            .seen_in   (seen[i]),
            .seen_out  (seen[i+1]),
            .key_out   (cell_key[i])
        );
    end

    always_comb begin
        ctl            = '0;
        ctl.hit        = seen[MAX_ENTRIES];
        count_next     = count_reg;
        rem_next       = rem_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_key_next   = out_key_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        MODE_INSERT: begin
                            ctl.insert = 1'b1;
                            if (!seen[MAX_ENTRIES]) begin
                                count_next = trimmed + CNT_W'(1);
                            end
                        end
                        MODE_REMOVE: begin
                            ctl.remove = 1'b1;
                            if (seen[MAX_ENTRIES]) begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        MODE_CLEAR: begin
                            count_next = '0;
                        end
                        MODE_READ: begin
                            rem_next   = count_reg;
                            state_next = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0) begin
                        out_key_next   = '0;
                        out_empty_next = 1'b1;
                        out_last_next  = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        ctl.rotate     = 1'b1;
                        out_key_next   = cell_key[0];
                        out_empty_next = 1'b0;
                        out_last_next  = (rem_reg == CNT_W'(1));
                        rem_next       = rem_reg - CNT_W'(1);
                        if (rem_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            rem_reg       <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_key_reg   <= out_key_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_key_reg);
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond chain length");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && mode == MODE_CLEAR |=> count_reg == '0)
        else $error("clear left entries behind");

    a_insert_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && mode == MODE_INSERT |=> count_reg != '0)
        else $error("insert left the list empty");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_empty_reg |-> out_last_reg)
        else $error("empty read result not marked last");

    a_read_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> count_reg == $past(count_reg))
        else $error("list length changed during read");

endmodule
